FILE: sv/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg: shared types and constants for the HSL to RGB converter
// Hue angle widths, sector boundaries and wrap constants used by the top
// level and the per-channel ramp pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int HUE_W   = 16;   // input hue width, two's complement
    localparam int DEG_W   = 9;    // wrapped angle 0..359
    localparam int RAMP_W  = 6;    // ramp position 0..60
    localparam int HUE_Q_W = 8;    // quotient of the biased hue by 360

    typedef logic [DEG_W-1:0]  t_deg;
    typedef logic [DEG_W:0]    t_deg_ext;
    typedef logic [RAMP_W-1:0] t_ramp;

    // Sector boundaries of the hue ramp
    localparam t_deg  DEG_60    = 9'd60;
    localparam t_deg  DEG_180   = 9'd180;
    localparam t_deg  DEG_240   = 9'd240;
    localparam t_ramp RAMP_FULL = 6'd60;

    localparam t_deg_ext DEG_360 = 10'd360;

    // Reciprocal of 360 scaled by 2^24; the estimate is exact or one short
    localparam logic [15:0] HUE_RECIP       = 16'd46603;
    localparam int          HUE_RECIP_SHIFT = 24;

    // Flipping the sign bit adds 32768, which is 8 modulo 360
    localparam t_deg_ext HUE_BIAS     = 10'd8;
    localparam t_deg_ext HUE_BIAS_WRAP = 10'd352;   // 360 - 8
    // Offsets from the biased remainder to red (+120) and blue (+240)
    localparam t_deg_ext RED_OFS       = 10'd112;
    localparam t_deg_ext BLUE_OFS      = 10'd232;

endpackage

FILE: sv/hsl_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_top: HSL to RGB colour converter
// o_valid is the last of the valid bits that travel alongside the data.
// Throughput: one transaction per cycle; busy never rises, as no stage waits.
// The five pipeline stages are: hue and L*S multiply, hue wrap
// and p/q forming, then three stages per channel for ramp, scale and clamp.
// Reset (synchronous, active low) clears the valid bits only; data drains.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_top
    import hsl_pkg::*;
#(
    parameter int FRACTION_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [HUE_W-1:0]  i_hue_degrees,
    input  logic [FRACTION_BITS:0]   i_saturation,
    input  logic [FRACTION_BITS:0]   i_lightness,
    output logic                     o_valid,
    output logic [FRACTION_BITS:0]   o_red,
    output logic [FRACTION_BITS:0]   o_green,
    output logic [FRACTION_BITS:0]   o_blue
);

    localparam int F    = FRACTION_BITS;
    localparam int V_W  = F + 1;          // saturation / lightness width
    localparam int LS_W = 2*F + 2;        // L*S product width
    localparam int W2   = 2*F + 4;        // signed p and q, 2F fraction bits
    localparam logic [V_W-1:0] HALF_VAL = V_W'(64'd1 << (F - 1));

    // The pipeline never holds a transaction, so the command port is always free
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Valid bits: travel alongside the data through all five stages
    // ------------------------------------------------------------------
    logic [4:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], accept};
        end
    end

    assign o_valid = r_vld[4];

    // ------------------------------------------------------------------
    // Stage 1: bias the hue to unsigned and multiply by the reciprocal of
    // 360; form L*S for the q term
    // ------------------------------------------------------------------
    logic [HUE_W-1:0]   hue_u;
    logic [2*HUE_W-1:0] n_hprod, r_hprod;
    logic [LS_W-1:0]    n_ls, r_ls;
    logic [HUE_W-1:0]   r_hue_u;
    logic [V_W-1:0]     r_l, r_s;

    always_comb begin
        // flip the sign bit: adds 32768, which is 8 more than a multiple of 360
        hue_u   = {~i_hue_degrees[HUE_W-1], i_hue_degrees[HUE_W-2:0]};
        n_hprod = (2*HUE_W)'(hue_u) * (2*HUE_W)'(HUE_RECIP);
        n_ls    = LS_W'(i_lightness) * LS_W'(i_saturation);
    end

    always_ff @(posedge i_clk) begin
        r_hprod <= n_hprod;
        r_hue_u <= hue_u;
        r_ls    <= n_ls;
        r_l     <= i_lightness;
        r_s     <= i_saturation;
    end

    // ------------------------------------------------------------------
    // Stage 2: remainder by 360 with one correction, remove the bias and
    // derive the three channel angles; form q and p exactly
    // ------------------------------------------------------------------
    logic [HUE_Q_W-1:0] hq;
    logic [HUE_W-1:0]   rem_full;
    t_deg_ext           rem0, rem1, red_sum, blu_sum, grn_val;
    t_deg               n_t_red, n_t_grn, n_t_blu;
    t_deg               r_t_red, r_t_grn, r_t_blu;
    logic               low_l;
    logic [W2-1:0]      l_w, s_w, ls_w;
    logic signed [W2-1:0] n_q2, n_p2, r_q2, r_p2;

    always_comb begin
        hq       = r_hprod[HUE_RECIP_SHIFT +: HUE_Q_W];
        rem_full = r_hue_u - (HUE_W'(hq) * HUE_W'(DEG_360));
        rem0     = rem_full[DEG_W:0];
        rem1     = (rem0 >= DEG_360) ? rem0 - DEG_360 : rem0;

        // green uses the hue itself; red and blue are offset by a third
        grn_val  = (rem1 >= HUE_BIAS) ? rem1 - HUE_BIAS : rem1 + HUE_BIAS_WRAP;
        red_sum  = rem1 + RED_OFS;
        blu_sum  = rem1 + BLUE_OFS;
        n_t_grn  = grn_val[DEG_W-1:0];
        n_t_red  = (red_sum >= DEG_360) ? DEG_W'(red_sum - DEG_360) : red_sum[DEG_W-1:0];
        n_t_blu  = (blu_sum >= DEG_360) ? DEG_W'(blu_sum - DEG_360) : blu_sum[DEG_W-1:0];

        low_l = (r_l < HALF_VAL);
        l_w   = W2'(r_l);
        s_w   = W2'(r_s);
        ls_w  = W2'(r_ls);
        if (low_l) begin
            n_q2 = (l_w << F) + ls_w;
        end else begin
            n_q2 = ((l_w + s_w) << F) - ls_w;
        end
        n_p2 = (l_w << (F + 1)) - n_q2;
    end

    always_ff @(posedge i_clk) begin
        r_t_red <= n_t_red;
        r_t_grn <= n_t_grn;
        r_t_blu <= n_t_blu;
        r_q2    <= n_q2;
        r_p2    <= n_p2;
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: one ramp pipeline per channel, ending in the output
    // register
    // ------------------------------------------------------------------
    hsl_chan #(.F(F)) u_chan_red (
        .i_clk   (i_clk),
        .i_t     (r_t_red),
        .i_p2    (r_p2),
        .i_q2    (r_q2),
        .o_value (o_red)
    );

    hsl_chan #(.F(F)) u_chan_green (
        .i_clk   (i_clk),
        .i_t     (r_t_grn),
        .i_p2    (r_p2),
        .i_q2    (r_q2),
        .o_value (o_green)
    );

    hsl_chan #(.F(F)) u_chan_blue (
        .i_clk   (i_clk),
        .i_t     (r_t_blu),
        .i_p2    (r_p2),
        .i_q2    (r_q2),
        .o_value (o_blue)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam logic [V_W-1:0] ONE_OUT = V_W'(64'd1 << F);

    // every accepted transaction yields a strobe when it leaves the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_valid)
        else $error("accepted transaction produced no result strobe");

    // no strobe without a matching accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 5))
        else $error("result strobe without a matching transaction");

    // results stay within 0..1.0
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= ONE_OUT && o_green <= ONE_OUT && o_blue <= ONE_OUT))
        else $error("result above full scale");

    // zero saturation gives a grey
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_saturation == '0) |-> ##5 (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give equal channels");

endmodule

FILE: sv/hsl_chan.sv
// ----------------------------------------------------------------------------
// hsl_chan: hue ramp, rounding and clamping for one colour channel
// Three register stages: ramp and weighted sum, scale and reciprocal
// multiply, quotient correction and clamp into the output register.
// ----------------------------------------------------------------------------
module hsl_chan
    import hsl_pkg::*;
#(
    parameter int F = 12
) (
    input  logic                i_clk,
    input  t_deg                i_t,
    input  logic signed [2*F+3:0] i_p2,
    input  logic signed [2*F+3:0] i_q2,
    output logic [F:0]          o_value
);

    localparam int W2    = 2*F + 4;
    localparam int W_NUM = W2 + 9;
    localparam int X_W   = W_NUM - F;
    localparam int Y_W   = F + 4;
    localparam int R_W   = F + 1;
    localparam int P_W   = Y_W + R_W;

    localparam logic [R_W-1:0]          RECIP    = R_W'((64'd1 << (F + 4)) / 64'd15);
    localparam logic [X_W-1:0]          CLAMP_LIM =
        X_W'(64'd60 * ((64'd1 << F) + 64'd1));
    localparam logic signed [W_NUM-1:0] HALF_DEN = W_NUM'(64'd30 << F);
    localparam logic [R_W-1:0]          ONE_VAL  = R_W'(64'd1 << F);
    localparam logic [Y_W-1:0]          FIFTEEN  = Y_W'(15);

    // stage 1: ramp position and weighted sum p*60 + (q-p)*k
    t_ramp                    k;
    logic signed [RAMP_W:0]   k_s;
    logic signed [W_NUM-1:0]  p2e, q2e, d, n_num;
    logic signed [W_NUM-1:0]  r_num;

    always_comb begin
        if (i_t < DEG_60) begin
            k = i_t[RAMP_W-1:0];
        end else if (i_t < DEG_180) begin
            k = RAMP_FULL;
        end else if (i_t < DEG_240) begin
            k = RAMP_W'(DEG_240 - i_t);
        end else begin
            k = '0;
        end
        k_s   = signed'({1'b0, k});
        p2e   = {{(W_NUM-W2){i_p2[W2-1]}}, i_p2};
        q2e   = {{(W_NUM-W2){i_q2[W2-1]}}, i_q2};
        d     = q2e - p2e;
        n_num = (p2e <<< 6) - (p2e <<< 2) + d * k_s;
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
    end

    // stage 2: add half a step, drop the fraction, divide by 4, multiply by 1/15
    logic [W_NUM-1:0] a;
    logic [X_W-1:0]   x;
    logic             n_pos, n_big;
    logic [Y_W-1:0]   n_y;
    logic [P_W-1:0]   n_prod;
    logic             r_pos, r_big;
    logic [Y_W-1:0]   r_y;
    logic [P_W-1:0]   r_prod;

    always_comb begin
        a      = r_num + HALF_DEN;
        x      = a[W_NUM-1:F];
        n_pos  = !r_num[W_NUM-1] && (r_num != '0);
        n_big  = (x >= CLAMP_LIM);
        n_y    = x[F+5:2];
        n_prod = P_W'(n_y) * P_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_big  <= n_big;
        r_y    <= n_y;
        r_prod <= n_prod;
    end

    // stage 3: fix a short quotient, then clamp
    logic [R_W-1:0] qe, qc, n_val;
    logic [Y_W-1:0] rem;
    logic [R_W-1:0] r_val;

    always_comb begin
        qe  = r_prod[P_W-1:F+4];
        rem = r_y - ((Y_W'(qe) << 4) - Y_W'(qe));
        qc  = (rem >= FIFTEEN) ? qe + R_W'(1) : qe;
        if (!r_pos) begin
            n_val = '0;
        end else if (r_big) begin
            n_val = ONE_VAL;
        end else begin
            n_val = qc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;

endmodule
